// ===== rtl/core/mtp_pkg.sv =====
// Shared types and constants for the multitap poll responder.
package mtp_pkg;

   // Fixed protocol bytes
   localparam logic [7:0] POLL_CMD  = 8'h42;
   localparam logic [7:0] MARK_BYTE = 8'h5A;
   localparam logic [7:0] IDLE_BYTE = 8'hFF;

   // Pad defaults after reset
   localparam logic [7:0]  PAD_MODEL_RST  = 8'h41;
   localparam logic [15:0] PAD_BUTTON_RST = 16'hFFFF;
   localparam logic [7:0]  PAD_AXIS_RST   = 8'h80;

   // Configuration register defaults
   localparam logic [7:0] TAP_ID_LOW_RST  = 8'h80;
   localparam logic [7:0] TAP_ID_HIGH_RST = 8'h5A;

   // Register index, taken from the word address
   localparam logic REG_TAP_ID_LOW  = 1'b0;
   localparam logic REG_TAP_ID_HIGH = 1'b1;

   // Request commands
   typedef enum logic [1:0] {
      CMD_READ   = 2'd0,
      CMD_WRITE  = 2'd1,
      CMD_UPDATE = 2'd2
   } cmd_type;

   // One pad slot as stored and as latched into a packet
   typedef struct packed {
      logic [7:0]       model;
      logic [15:0]      buttons;
      logic             analog;
      logic [3:0][7:0]  axes;
   } pad_rec_type;

   // One response transaction
   typedef struct packed {
      logic [7:0] read_byte;
      logic       more_pending;
   } rsp_item_type;

endpackage

// ===== rtl/core/multitap_poll_responder_top.sv =====
// Multitap poll responder: pad store, packet latch, byte sequencer and CSRs.
//
//   Channel   Direction  Handshake                 Payload
//   req_      in         req_valid / req_ready     cmd, host byte, pad slot fields
//   rsp_      out        rsp_valid / rsp_ready     read_byte, more_pending
//   csr_      in         APB psel/penable/pready   tap ID bytes
//
// One request transaction per cycle while req_ready is high; its response is registered in the response queue.
// The packet is latched from the pad store in parallel on the first read.
// A two-entry response queue keeps requests flowing while rsp_ready is low;
// req_ready drops only when both entries are occupied.
// Synchronous active-high reset; no clearing pass is needed.
module multitap_poll_responder_top
   import mtp_pkg::*;
#(
   parameter int PAD_SLOTS = 4
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic [7:0]  req_host_byte,
   input  logic [1:0]  req_slot,
   input  logic [7:0]  req_pad_model,
   input  logic [15:0] req_buttons,
   input  logic        req_analog_on,
   input  logic [7:0]  req_axis_a,
   input  logic [7:0]  req_axis_b,
   input  logic [7:0]  req_axis_c,
   input  logic [7:0]  req_axis_d,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_read_byte,
   output logic        rsp_more_pending,
   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int PKT_LEN = 3 + 8 * PAD_SLOTS;
   localparam int POS_W   = $clog2(PKT_LEN);
   localparam int SLOT_W  = (PAD_SLOTS > 1) ? $clog2(PAD_SLOTS) : 1;

   // Configuration registers
   logic [7:0] tap_id_low_ff;
   logic [7:0] tap_id_high_ff;
   logic       csr_write;

   // Sequencer state
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             ready_ff, ready_in;

   // Pad store and packet snapshot
   pad_rec_type pad_ff  [PAD_SLOTS];
   pad_rec_type snap_ff [PAD_SLOTS];
   logic [7:0]  snap_id_low_ff;
   logic [7:0]  snap_id_high_ff;

   // Per-transaction control
   logic             req_fire;
   logic             do_latch;
   logic             do_update;
   logic [SLOT_W-1:0] upd_slot;
   pad_rec_type      upd_rec;
   logic [POS_W-1:0] body_idx;
   logic [SLOT_W-1:0] rd_slot;
   pad_rec_type      rd_rec;
   logic [7:0]       body_byte;
   rsp_item_type     result;
   rsp_item_type     out_item;
   logic             queue_room;

   // APB register access
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      unique case (csr_paddr[2])
         REG_TAP_ID_LOW:  csr_prdata = {24'd0, tap_id_low_ff};
         REG_TAP_ID_HIGH: csr_prdata = {24'd0, tap_id_high_ff};
         default:         csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_id_low_ff  <= TAP_ID_LOW_RST;
         tap_id_high_ff <= TAP_ID_HIGH_RST;
      end else if (csr_write) begin
         unique case (csr_paddr[2])
            REG_TAP_ID_LOW:  tap_id_low_ff  <= csr_pwdata[7:0];
            REG_TAP_ID_HIGH: tap_id_high_ff <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   assign req_ready = queue_room;
   assign req_fire  = req_valid && req_ready;

   // Packet byte selection from the snapshot
   assign body_idx = pos_ff - POS_W'(3);
   assign rd_slot  = body_idx[SLOT_W+2:3];
   assign rd_rec   = snap_ff[rd_slot];

   always_comb begin
      case (body_idx[2:0])
         3'd0:    body_byte = rd_rec.model;
         3'd1:    body_byte = MARK_BYTE;
         3'd2:    body_byte = rd_rec.buttons[7:0];
         3'd3:    body_byte = rd_rec.buttons[15:8];
         default: body_byte = rd_rec.analog ? rd_rec.axes[body_idx[1:0]] : IDLE_BYTE;
      endcase
   end

   // Pad update payload
   assign upd_slot       = SLOT_W'(req_slot);
   assign upd_rec.model   = req_pad_model;
   assign upd_rec.buttons = req_buttons;
   assign upd_rec.analog  = req_analog_on;
   assign upd_rec.axes    = {req_axis_d, req_axis_c, req_axis_b, req_axis_a};

   // Command decode and sequencer next state
   always_comb begin
      pos_in           = pos_ff;
      ready_in         = ready_ff;
      do_latch         = 1'b0;
      do_update        = 1'b0;
      result.read_byte = 8'd0;
      unique case (cmd_type'(req_cmd))
         CMD_READ: begin
            if (pos_ff == '0) begin
               do_latch         = 1'b1;
               result.read_byte = IDLE_BYTE;
            end else if (pos_ff == POS_W'(1)) begin
               result.read_byte = snap_id_low_ff;
            end else if (pos_ff == POS_W'(2)) begin
               result.read_byte = snap_id_high_ff;
            end else begin
               result.read_byte = body_byte;
            end
            if (pos_ff == POS_W'(PKT_LEN - 1)) begin
               pos_in   = '0;
               ready_in = 1'b0;
            end else begin
               pos_in   = pos_ff + POS_W'(1);
               ready_in = 1'b1;
            end
         end
         CMD_WRITE: begin
            // non-poll command at position 1 aborts the transfer
            if (pos_ff == POS_W'(1) && req_host_byte != POLL_CMD) begin
               pos_in   = '0;
               ready_in = 1'b0;
            end
         end
         CMD_UPDATE: begin
            do_update = (32'(req_slot) < PAD_SLOTS);
         end
         default: ;
      endcase
      result.more_pending = ready_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         ready_ff <= 1'b0;
      end else if (req_fire) begin
         pos_ff   <= pos_in;
         ready_ff <= ready_in;
      end
   end

   // Pad store, reset to digital pads with nothing pressed
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < PAD_SLOTS; s++) begin
            pad_ff[s].model   <= PAD_MODEL_RST;
            pad_ff[s].buttons <= PAD_BUTTON_RST;
            pad_ff[s].analog  <= 1'b0;
            pad_ff[s].axes    <= {4{PAD_AXIS_RST}};
         end
      end else if (req_fire && do_update) begin
         pad_ff[upd_slot] <= upd_rec;
      end
   end

   // Packet snapshot, taken on the first read of a transfer
   always_ff @(posedge clock) begin
      if (req_fire && do_latch) begin
         snap_id_low_ff  <= tap_id_low_ff;
         snap_id_high_ff <= tap_id_high_ff;
         for (int s = 0; s < PAD_SLOTS; s++) begin
            snap_ff[s] <= pad_ff[s];
         end
      end
   end

   mtp_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_fire),
      .push_item (result),
      .has_room  (queue_room),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_item  (out_item)
   );

   assign rsp_read_byte    = out_item.read_byte;
   assign rsp_more_pending = out_item.more_pending;

`ifndef SYNTHESIS
   a_ready_tracks_pos: assert property (@(posedge clock) disable iff (reset)
      ready_ff == (pos_ff != '0))
      else $error("ready flag out of step with byte position");

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      32'(pos_ff) < PKT_LEN)
      else $error("byte position past end of packet");

   a_abort: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_cmd == CMD_WRITE && pos_ff == POS_W'(1)
       && req_host_byte != POLL_CMD) |=> (pos_ff == '0 && !ready_ff))
      else $error("non-poll command did not abort transfer");

   a_update_idle: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_cmd == CMD_UPDATE) |=> $stable(pos_ff))
      else $error("pad update moved the byte position");
`endif

endmodule

// ===== rtl/core/mtp_out_queue.sv =====
// Two-entry response queue that decouples the engine from response stalls.
module mtp_out_queue
   import mtp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  rsp_item_type push_item,
   output logic         has_room,
   output logic         out_valid,
   input  logic         out_ready,
   output rsp_item_type out_item
);

   rsp_item_type entry_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         do_push;
   logic         do_pop;

   assign has_room  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_item  = entry_ff[rd_ptr_ff];
   assign do_push   = push && has_room;
   assign do_pop    = out_valid && out_ready;

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage, no reset needed
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("response queue count out of range");

   a_push_empty: assert property (@(posedge clock) disable iff (reset)
      (do_push && count_ff == 2'd0) |=> out_valid)
      else $error("pushed transaction not visible");

   a_full_hold: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd2 && !do_pop) |=> (count_ff == 2'd2 && !has_room))
      else $error("full queue changed without a pop");
`endif

endmodule

// ===== verif/testbench.sv =====
// Testbench for the multitap poll responder: predictor, scoreboard and stimulus.
`timescale 1ns / 100ps

module testbench
   import mtp_pkg::*;
();

   localparam int PAD_SLOTS   = 4;
   localparam int PKT_BYTES   = 3 + 8 * PAD_SLOTS;
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 175;
   localparam int HOLD_CYCLES = 80;
   localparam int CYCLE_LIMIT = 300000;

   // cmd encoding the block leaves unused
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   // One request transaction, field order matches the req_ ports
   typedef struct packed {
      logic [1:0]  cmd;
      logic [7:0]  host_byte;
      logic [1:0]  slot;
      logic [7:0]  pad_model;
      logic [15:0] buttons;
      logic        analog_on;
      logic [7:0]  axis_a;
      logic [7:0]  axis_b;
      logic [7:0]  axis_c;
      logic [7:0]  axis_d;
   } req_item_type;

   // Poll predictor plus queue of expected response transactions
   class poll_scoreboard;
      logic [7:0]   tap_lo;
      logic [7:0]   tap_hi;
      int           byte_pos;
      logic         more_flag;
      logic [7:0]   host_cmd;
      logic [7:0]   packet [PKT_BYTES];
      pad_rec_type  pads [PAD_SLOTS];
      rsp_item_type expected_q [$];
      int errors, n_reads, n_writes, n_updates, n_unused, n_packets;

      function new();
         tap_lo    = TAP_ID_LOW_RST;
         tap_hi    = TAP_ID_HIGH_RST;
         byte_pos  = 0;
         more_flag = 1'b0;
         host_cmd  = 8'h00;
         foreach (packet[i]) packet[i] = 8'h00;
         foreach (pads[s]) begin
            pads[s].model   = PAD_MODEL_RST;
            pads[s].buttons = PAD_BUTTON_RST;
            pads[s].analog  = 1'b0;
            pads[s].axes    = {4{PAD_AXIS_RST}};
         end
         errors = 0;
         n_reads = 0; n_writes = 0; n_updates = 0; n_unused = 0; n_packets = 0;
      endfunction

      function void set_tap_id(logic reg_idx, logic [7:0] value);
         if (reg_idx == REG_TAP_ID_LOW) tap_lo = value;
         else tap_hi = value;
      endfunction

      function logic [7:0] tap_id(logic reg_idx);
         return (reg_idx == REG_TAP_ID_LOW) ? tap_lo : tap_hi;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // Snapshot of all pads: hi-Z, ID bytes, then eight bytes per slot
      function void latch_packet();
         int base;
         packet[0] = IDLE_BYTE;
         packet[1] = tap_lo;
         packet[2] = tap_hi;
         for (int s = 0; s < PAD_SLOTS; s++) begin
            base = 3 + 8 * s;
            packet[base]     = pads[s].model;
            packet[base + 1] = MARK_BYTE;
            packet[base + 2] = pads[s].buttons[7:0];
            packet[base + 3] = pads[s].buttons[15:8];
            for (int k = 0; k < 4; k++)
               packet[base + 4 + k] = pads[s].analog ? pads[s].axes[k] : IDLE_BYTE;
         end
      endfunction

      function void note_request(req_item_type r);
         rsp_item_type exp_rsp;
         exp_rsp = '0;
         case (r.cmd)
            CMD_READ: begin
               n_reads++;
               if (byte_pos >= PKT_BYTES) byte_pos = 0;
               if (byte_pos == 0) latch_packet();
               exp_rsp.read_byte = packet[byte_pos];
               byte_pos++;
               if (byte_pos >= PKT_BYTES) begin
                  byte_pos  = 0;
                  more_flag = 1'b0;
                  n_packets++;
               end else begin
                  more_flag = 1'b1;
               end
            end
            CMD_WRITE: begin
               n_writes++;
               // only the command byte slot counts; anything but a poll aborts
               if (byte_pos == 1) begin
                  host_cmd = r.host_byte;
                  if (host_cmd != POLL_CMD) begin
                     byte_pos  = 0;
                     more_flag = 1'b0;
                  end
               end
            end
            CMD_UPDATE: begin
               n_updates++;
               if (r.slot < PAD_SLOTS) begin
                  pads[r.slot].model   = r.pad_model;
                  pads[r.slot].buttons = r.buttons;
                  pads[r.slot].analog  = r.analog_on;
                  pads[r.slot].axes    = {r.axis_d, r.axis_c, r.axis_b, r.axis_a};
               end
            end
            default: n_unused++;
         endcase
         exp_rsp.more_pending = more_flag;
         expected_q.push_back(exp_rsp);
      endfunction

      function void check_response(rsp_item_type got);
         rsp_item_type exp_rsp;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected response, read_byte %h more_pending %b",
                     $time, got.read_byte, got.more_pending);
            errors++;
            return;
         end
         exp_rsp = expected_q.pop_front();
         if (got.read_byte !== exp_rsp.read_byte) begin
            $display("%0t: read_byte mismatch, expected %h actual %h",
                     $time, exp_rsp.read_byte, got.read_byte);
            errors++;
         end
         if (got.more_pending !== exp_rsp.more_pending) begin
            $display("%0t: more_pending mismatch, expected %b actual %b",
                     $time, exp_rsp.more_pending, got.more_pending);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_cmd;
   logic [7:0]  req_host_byte;
   logic [1:0]  req_slot;
   logic [7:0]  req_pad_model;
   logic [15:0] req_buttons;
   logic        req_analog_on;
   logic [7:0]  req_axis_a;
   logic [7:0]  req_axis_b;
   logic [7:0]  req_axis_c;
   logic [7:0]  req_axis_d;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [7:0]  rsp_read_byte;
   logic        rsp_more_pending;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   poll_scoreboard sb = new();
   bit  quiet;          // no idling on either side
   bit  rsp_hold_long;  // receiver holds off for a long stretch
   int  cycle_count;
   int  id_settings;

   multitap_poll_responder_top #(
      .PAD_SLOTS(PAD_SLOTS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_cmd(req_cmd),
      .req_host_byte(req_host_byte),
      .req_slot(req_slot),
      .req_pad_model(req_pad_model),
      .req_buttons(req_buttons),
      .req_analog_on(req_analog_on),
      .req_axis_a(req_axis_a),
      .req_axis_b(req_axis_b),
      .req_axis_c(req_axis_c),
      .req_axis_d(req_axis_d),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_read_byte(rsp_read_byte),
      .rsp_more_pending(rsp_more_pending),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // 12 ns clock
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Some tests failed");
         $finish;
      end
   end

   // Transaction monitor: requests are noted before responses are checked
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            sb.note_request(req_item_type'({req_cmd, req_host_byte, req_slot, req_pad_model,
                                            req_buttons, req_analog_on, req_axis_a,
                                            req_axis_b, req_axis_c, req_axis_d}));
         if (rsp_valid && rsp_ready)
            sb.check_response(rsp_item_type'({rsp_read_byte, rsp_more_pending}));
      end
   end

   // Response receiver: random stalls, one long hold-off on request
   initial begin
      int stall;
      rsp_ready <= 1'b0;
      @(negedge reset);
      forever begin
         if (rsp_hold_long) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_hold_long = 1'b0;
         end
         stall = quiet ? 0 : $urandom_range(0, 5);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   function automatic req_item_type random_item(logic [1:0] cmd);
      req_item_type item;
      item.cmd       = cmd;
      item.host_byte = 8'($urandom_range(0, 255));
      item.slot      = 2'($urandom_range(0, 3));
      item.pad_model = 8'($urandom_range(0, 255));
      item.buttons   = 16'($urandom_range(0, 65535));
      item.analog_on = 1'($urandom_range(0, 1));
      item.axis_a    = 8'($urandom_range(0, 255));
      item.axis_b    = 8'($urandom_range(0, 255));
      item.axis_c    = 8'($urandom_range(0, 255));
      item.axis_d    = 8'($urandom_range(0, 255));
      return item;
   endfunction

   // Offer one request after a random gap and wait for acceptance
   task automatic send_request(input req_item_type item);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_cmd       <= item.cmd;
      req_host_byte <= item.host_byte;
      req_slot      <= item.slot;
      req_pad_model <= item.pad_model;
      req_buttons   <= item.buttons;
      req_analog_on <= item.analog_on;
      req_axis_a    <= item.axis_a;
      req_axis_b    <= item.axis_b;
      req_axis_c    <= item.axis_c;
      req_axis_d    <= item.axis_d;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_cmd(input logic [1:0] cmd);
      send_request(random_item(cmd));
   endtask

   task automatic send_host(input logic [7:0] value);
      req_item_type item;
      item = random_item(CMD_WRITE);
      item.host_byte = value;
      send_request(item);
   endtask

   task automatic send_update(input logic [1:0] slot, input logic [7:0] model,
                              input logic [15:0] buttons, input logic analog_on,
                              input logic [31:0] axes);
      req_item_type item;
      item = random_item(CMD_UPDATE);
      item.slot      = slot;
      item.pad_model = model;
      item.buttons   = buttons;
      item.analog_on = analog_on;
      {item.axis_a, item.axis_b, item.axis_c, item.axis_d} = axes;
      send_request(item);
   endtask

   // Stop offering and wait until every response has come back
   task automatic drain();
      req_valid <= 1'b0;
      // let the monitor record the last accepted request first
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // APB read, compared with the predictor's copy of the register
   task automatic csr_check(input logic reg_idx);
      logic [7:0] want;
      want = sb.tap_id(reg_idx);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {reg_idx, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[7:0] !== want) begin
         $display("%0t: register %0d readback mismatch, expected %h actual %h",
                  $time, reg_idx, want, csr_prdata[7:0]);
         sb.errors++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_write(input logic reg_idx, input logic [7:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_idx, 2'b00};
      csr_pwdata  <= {24'h0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.set_tap_id(reg_idx, value);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_check(reg_idx);
   endtask

   // One random stretch: mostly complete polls, plus updates, aborts and noise
   task automatic run_sequence(output int count);
      int kind;
      int reads;
      count = 0;
      kind  = $urandom_range(0, 99);
      if (kind < 55) begin
         send_cmd(CMD_READ);
         send_host(POLL_CMD);
         count = 2;
         reads = ($urandom_range(0, 3) == 0) ? $urandom_range(1, PKT_BYTES - 2) : PKT_BYTES - 1;
         repeat (reads) begin
            if ($urandom_range(0, 39) == 0) begin
               send_cmd(CMD_UPDATE);
               count++;
            end
            send_cmd(CMD_READ);
            count++;
         end
      end else if (kind < 70) begin
         send_cmd(CMD_UPDATE);
         count = 1;
      end else if (kind < 82) begin
         // host byte at the command slot, usually not a poll
         send_cmd(CMD_READ);
         send_host(8'($urandom_range(0, 255)));
         count = 2;
      end else begin
         repeat ($urandom_range(1, 4)) begin
            send_cmd(2'($urandom_range(0, 3)));
            count++;
         end
      end
   endtask

   initial begin
      int sent;
      int n;
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_cmd       <= CMD_READ;
      req_host_byte <= 8'h00;
      req_slot      <= 2'd0;
      req_pad_model <= 8'h00;
      req_buttons   <= 16'h0000;
      req_analog_on <= 1'b0;
      req_axis_a    <= 8'h00;
      req_axis_b    <= 8'h00;
      req_axis_c    <= 8'h00;
      req_axis_d    <= 8'h00;
      csr_psel      <= 1'b0;
      csr_penable   <= 1'b0;
      csr_pwrite    <= 1'b0;
      csr_paddr     <= 3'd0;
      csr_pwdata    <= 32'h0;
      quiet         = 1'b0;
      rsp_hold_long = 1'b0;
      id_settings   = 1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // register defaults after reset
      csr_check(REG_TAP_ID_LOW);
      csr_check(REG_TAP_ID_HIGH);

      // directed: pad extremes, unused command, stray and aborting host bytes
      send_update(2'd0, 8'hFF, 16'hFFFF, 1'b1, 32'hFFFF_FFFF);
      send_update(2'd3, 8'h00, 16'h0000, 1'b0, 32'h0000_0000);
      send_update(2'd1, 8'h5A, 16'hA55A, 1'b1, 32'h00FF_807F);
      send_cmd(CMD_UNUSED);
      send_host(POLL_CMD);            // no transfer yet: ignored
      send_cmd(CMD_READ);             // latches the packet
      send_host(8'hFF);               // not a poll: aborts
      send_cmd(CMD_READ);
      send_host(POLL_CMD);
      send_cmd(CMD_READ);
      send_cmd(CMD_READ);
      send_host(8'h00);               // past the command slot: ignored
      send_cmd(CMD_UNUSED);
      send_update(2'd2, 8'h73, 16'h0F0F, 1'b1, 32'h1234_5678);  // after the latch
      repeat (6) send_cmd(CMD_READ);

      // random phases under different ID settings
      for (int ph = 0; ph < PHASES; ph++) begin
         drain();
         if (ph > 0) begin
            case (ph)
               1: begin
                  csr_write(REG_TAP_ID_LOW, 8'h00);
                  csr_write(REG_TAP_ID_HIGH, 8'h00);
               end
               2: begin
                  csr_write(REG_TAP_ID_LOW, 8'hFF);
                  csr_write(REG_TAP_ID_HIGH, 8'hFF);
               end
               3: begin
                  csr_write(REG_TAP_ID_LOW, 8'h00);
                  csr_write(REG_TAP_ID_HIGH, 8'hFF);
               end
               4: csr_write(REG_TAP_ID_HIGH, 8'($urandom_range(0, 255)));
               default: begin
                  csr_write(REG_TAP_ID_LOW, 8'($urandom_range(0, 255)));
                  csr_write(REG_TAP_ID_HIGH, 8'($urandom_range(0, 255)));
               end
            endcase
            id_settings++;
         end
         quiet = (ph == 2 || ph == 5);
         if (ph == 5) rsp_hold_long = 1'b1;
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            run_sequence(n);
            sent += n;
         end
      end

      drain();
      repeat (10) @(posedge clock);
      $display("Covered %0d requests: %0d reads, %0d host writes, %0d pad updates, %0d unused.",
               sb.n_reads + sb.n_writes + sb.n_updates + sb.n_unused,
               sb.n_reads, sb.n_writes, sb.n_updates, sb.n_unused);
      $display("%0d complete packets read out across %0d tap ID settings.",
               sb.n_packets, id_settings);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
